// ===== sv/wtosc_pkg.sv =====
// Shared constants, opcodes and the sequencer state type of the wavetable oscillator.
// Used by the request/response interfaces, the table RAM users and the top level.
package wtosc_pkg;

  localparam int TABLE_DEPTH     = 2048;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int OPCODE_W  = 2;
  localparam int TADDR_W   = 11;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int LENGTH_W  = 12;
  localparam int INC_W     = 27;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = INC_W;

  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int LEN_W    = $clog2(TABLE_DEPTH + 1);
  localparam int SPAN_W   = LEN_W + PHASE_FRAC_BITS;
  localparam int ACC_W    = ((SPAN_W > INC_W) ? SPAN_W : INC_W) + 1;
  localparam int CNT_W    = $clog2(ACC_W + 1);
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int MIX_W    = DIFF_W + PHASE_FRAC_BITS;
  localparam int GPROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W = GPROD_W - 15;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_NOTE  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_READ_A,
    S_READ_B,
    S_LOAD_B,
    S_INTERP,
    S_GAIN,
    S_DONE
  } state_t;

endpackage

// ===== sv/wtosc_req_if.sv =====
// Request channel of the wavetable oscillator: valid/ready plus the request fields.
// Depends on wtosc_pkg for the field widths.
interface wtosc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [wtosc_pkg::OPCODE_W-1:0]       opcode;
  logic [wtosc_pkg::TADDR_W-1:0]        table_address;
  logic signed [wtosc_pkg::SAMPLE_W-1:0] table_value;
  logic [wtosc_pkg::GAIN_W-1:0]         note_velocity;

  modport source (output valid, opcode, table_address, table_value, note_velocity,
                  input ready);
  modport sink (input valid, opcode, table_address, table_value, note_velocity,
                output ready);
endinterface

// ===== sv/wtosc_rsp_if.sv =====
// Response channel of the wavetable oscillator: valid/ready plus one output sample.
// Depends on wtosc_pkg for the sample width.
interface wtosc_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wtosc_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ===== sv/wtosc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package dependency.
module wtosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/wavetable_oscillator_lerp.sv =====
// Wavetable oscillator with linear interpolation, top level and bit-serial datapath.
// Depends on wtosc_pkg, wtosc_req_if, wtosc_rsp_if and wtosc_ram.
//
//   port  | kind       | moves
//   ------+------------+-----------------------------------------------
//   req   | valid/ready| opcode, table_address, table_value, note_velocity
//   rsp   | valid/ready| sample_out (one per tick request)
//   cfg_* | write only | table_length (index 0), phase_increment (index 1)
//
// Table writes and note starts take effect at the edge that accepts them. A tick
// runs the bit-serial phase remainder (one bit a cycle over the 29-bit accumulator),
// two reads on the single RAM read port, then two shift-add multiplies.
// A new request is taken while an earlier sample still waits in the output register.
// Reset zeroes phase, increment, gain, valid; length is set to 64; RAM is not cleared.
module wavetable_oscillator_lerp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtosc_pkg::CFG_W-1:0]     cfg_data,
  wtosc_req_if.sink                       req,
  wtosc_rsp_if.source                     rsp
);

  localparam int F = wtosc_pkg::PHASE_FRAC_BITS;

  wtosc_pkg::state_t state, state_next;

  logic [wtosc_pkg::LENGTH_W-1:0] table_length;
  logic [wtosc_pkg::INC_W-1:0]    phase_increment;
  logic [wtosc_pkg::ACC_W-1:0]    acc;
  logic [wtosc_pkg::GAIN_W-1:0]   note_gain;

  logic [wtosc_pkg::LEN_W-1:0]    len;
  logic [wtosc_pkg::LEN_W-1:0]    len_q;
  logic [wtosc_pkg::SPAN_W-1:0]   span_q;
  logic [wtosc_pkg::ACC_W-1:0]    dvd;
  logic [wtosc_pkg::SPAN_W-1:0]   rem;
  logic [wtosc_pkg::SPAN_W-1:0]   rem_next;
  logic [wtosc_pkg::SPAN_W:0]     trial;
  logic [wtosc_pkg::CNT_W-1:0]    cnt;
  logic [F-1:0]                   frac;
  logic [wtosc_pkg::GAIN_W-1:0]   gsh;

  logic [wtosc_pkg::LEN_W-1:0]    idx_full;
  logic [wtosc_pkg::LEN_W-1:0]    nxt_full;
  logic [wtosc_pkg::ADDR_W-1:0]   nxt;

  logic signed [wtosc_pkg::SAMPLE_W-1:0] a_smp;
  logic signed [wtosc_pkg::DIFF_W-1:0]   diff;
  logic signed [wtosc_pkg::MIX_W-1:0]    prod1;
  logic signed [wtosc_pkg::DIFF_W-1:0]   mix_wide;
  logic signed [wtosc_pkg::SAMPLE_W-1:0] mix;
  logic signed [wtosc_pkg::GPROD_W-1:0]  prod2;
  logic signed [wtosc_pkg::SCALED_W-1:0] scaled;
  logic signed [wtosc_pkg::SAMPLE_W-1:0] sat;

  logic                                  out_valid;
  logic signed [wtosc_pkg::SAMPLE_W-1:0] out_data;

  logic req_acc;
  logic tick_acc;
  logic out_load;
  logic ram_we;
  logic [wtosc_pkg::ADDR_W-1:0]   ram_waddr;
  logic [wtosc_pkg::ADDR_W-1:0]   ram_raddr;
  logic [wtosc_pkg::SAMPLE_W-1:0] ram_rdata;

  wtosc_ram #(
    .WIDTH(wtosc_pkg::SAMPLE_W),
    .DEPTH(wtosc_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.table_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (table_length == '0) begin
      len = wtosc_pkg::LEN_W'(1);
    end else if (32'(table_length) > 32'(wtosc_pkg::TABLE_DEPTH)) begin
      len = wtosc_pkg::LEN_W'(wtosc_pkg::TABLE_DEPTH);
    end else begin
      len = wtosc_pkg::LEN_W'(table_length);
    end
  end

  assign trial    = {rem, dvd[wtosc_pkg::ACC_W-1]};
  assign rem_next = (trial >= {1'b0, span_q}) ? wtosc_pkg::SPAN_W'(trial - {1'b0, span_q})
                                               : wtosc_pkg::SPAN_W'(trial);
  assign idx_full = rem[wtosc_pkg::SPAN_W-1:F];
  assign nxt_full = idx_full + wtosc_pkg::LEN_W'(1);
  assign nxt      = (nxt_full >= len_q) ? '0 : nxt_full[wtosc_pkg::ADDR_W-1:0];

  assign mix_wide = {a_smp[wtosc_pkg::SAMPLE_W-1], a_smp} + prod1[wtosc_pkg::MIX_W-1:F];
  assign mix      = mix_wide[wtosc_pkg::SAMPLE_W-1:0];
  assign scaled   = prod2[wtosc_pkg::GPROD_W-1:15];

  always_comb begin
    if (scaled[wtosc_pkg::SCALED_W-1:wtosc_pkg::SAMPLE_W-1] == '0 ||
        scaled[wtosc_pkg::SCALED_W-1:wtosc_pkg::SAMPLE_W-1] == '1) begin
      sat = scaled[wtosc_pkg::SAMPLE_W-1:0];
    end else if (scaled[wtosc_pkg::SCALED_W-1]) begin
      sat = {1'b1, {(wtosc_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(wtosc_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // Next-state logic of the tick sequencer.
  always_comb begin
    state_next = state;
    case (state)
      wtosc_pkg::S_IDLE: begin
        if (tick_acc) begin
          state_next = wtosc_pkg::S_WRAP;
        end
      end
      wtosc_pkg::S_WRAP: begin
        if (cnt == wtosc_pkg::CNT_W'(wtosc_pkg::ACC_W - 1)) begin
          state_next = wtosc_pkg::S_READ_A;
        end
      end
      wtosc_pkg::S_READ_A: state_next = wtosc_pkg::S_READ_B;
      wtosc_pkg::S_READ_B: state_next = wtosc_pkg::S_LOAD_B;
      wtosc_pkg::S_LOAD_B: state_next = wtosc_pkg::S_INTERP;
      wtosc_pkg::S_INTERP: begin
        if (cnt == wtosc_pkg::CNT_W'(F - 1)) begin
          state_next = wtosc_pkg::S_GAIN;
        end
      end
      wtosc_pkg::S_GAIN: begin
        if (cnt == wtosc_pkg::CNT_W'(wtosc_pkg::GAIN_W - 1)) begin
          state_next = wtosc_pkg::S_DONE;
        end
      end
      wtosc_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = wtosc_pkg::S_IDLE;
        end
      end
      default: state_next = wtosc_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    ram_raddr = idx_full[wtosc_pkg::ADDR_W-1:0];
    case (state)
      wtosc_pkg::S_IDLE:   req.ready = 1'b1;
      wtosc_pkg::S_READ_B: ram_raddr = nxt;
      wtosc_pkg::S_DONE:   out_load  = !out_valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign req_acc   = req.valid && req.ready;
  assign tick_acc  = req_acc && (req.opcode == wtosc_pkg::OP_TICK);
  assign ram_we    = req_acc && (req.opcode == wtosc_pkg::OP_WRITE) &&
                     (32'(req.table_address) < 32'(wtosc_pkg::TABLE_DEPTH));
  assign ram_waddr = wtosc_pkg::ADDR_W'(req.table_address);

  assign rsp.valid      = out_valid;
  assign rsp.sample_out = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= wtosc_pkg::S_IDLE;
      table_length    <= wtosc_pkg::LENGTH_RESET;
      phase_increment <= '0;
      acc             <= '0;
      note_gain       <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == wtosc_pkg::CFG_TABLE_LENGTH) begin
          table_length <= cfg_data[wtosc_pkg::LENGTH_W-1:0];
        end else if (cfg_index == wtosc_pkg::CFG_PHASE_INCREMENT) begin
          phase_increment <= cfg_data[wtosc_pkg::INC_W-1:0];
        end
      end
      if (req_acc && req.opcode == wtosc_pkg::OP_NOTE) begin
        note_gain <= req.note_velocity;
      end
      if (state == wtosc_pkg::S_READ_A) begin
        acc <= wtosc_pkg::ACC_W'(rem) + wtosc_pkg::ACC_W'(phase_increment);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wtosc_pkg::S_IDLE: begin
        dvd    <= acc;
        rem    <= '0;
        cnt    <= '0;
        len_q  <= len;
        span_q <= {len, {F{1'b0}}};
      end
      wtosc_pkg::S_WRAP: begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt + wtosc_pkg::CNT_W'(1);
      end
      wtosc_pkg::S_READ_A: begin
        frac <= rem[F-1:0];
      end
      wtosc_pkg::S_READ_B: begin
        a_smp <= ram_rdata;
      end
      wtosc_pkg::S_LOAD_B: begin
        diff  <= $signed({ram_rdata[wtosc_pkg::SAMPLE_W-1], ram_rdata}) -
                 $signed({a_smp[wtosc_pkg::SAMPLE_W-1], a_smp});
        prod1 <= '0;
        gsh   <= note_gain;
        cnt   <= '0;
      end
      wtosc_pkg::S_INTERP: begin
        prod1 <= (prod1 <<< 1) +
                 (frac[F-1] ? {{F{diff[wtosc_pkg::DIFF_W-1]}}, diff} : '0);
        frac  <= frac << 1;
        prod2 <= '0;
        if (cnt == wtosc_pkg::CNT_W'(F - 1)) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + wtosc_pkg::CNT_W'(1);
        end
      end
      wtosc_pkg::S_GAIN: begin
        prod2 <= (prod2 <<< 1) +
                 (gsh[wtosc_pkg::GAIN_W-1] ?
                  {{(wtosc_pkg::GPROD_W - wtosc_pkg::SAMPLE_W){mix[wtosc_pkg::SAMPLE_W-1]}},
                   mix} : '0);
        gsh   <= gsh << 1;
        cnt   <= cnt + wtosc_pkg::CNT_W'(1);
      end
      wtosc_pkg::S_DONE: begin
        if (out_load) begin
          out_data <= sat;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_tick_starts_wrap: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> state == wtosc_pkg::S_WRAP)
    else $error("tick request did not start the phase wrap");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    state == wtosc_pkg::S_WRAP |-> rem < span_q)
    else $error("phase remainder not below the span");

  a_index_in_length: assert property (@(posedge clk) disable iff (rst)
    state == wtosc_pkg::S_READ_A |-> idx_full < len_q)
    else $error("table index outside the length in use");

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    state == wtosc_pkg::S_READ_B |->
      acc == wtosc_pkg::ACC_W'($past(rem)) + wtosc_pkg::ACC_W'($past(phase_increment)))
    else $error("phase accumulator not advanced by the increment");
`endif

endmodule

// ===== verif/tb_wavetable_oscillator_lerp.sv =====
// Self-checking testbench for the wavetable oscillator with linear interpolation.
// Drives random and directed requests, predicts every tick sample and compares responses.
// Depends on wtosc_pkg, wtosc_req_if, wtosc_rsp_if and wavetable_oscillator_lerp.
module tb_wavetable_oscillator_lerp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wtosc_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQUESTS = 135;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [wtosc_pkg::OPCODE_W-1:0] op;
    logic [wtosc_pkg::TADDR_W-1:0]  addr;
    logic [wtosc_pkg::SAMPLE_W-1:0] value;
    logic [wtosc_pkg::GAIN_W-1:0]   velocity;
  } osc_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [wtosc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wtosc_pkg::CFG_W-1:0] cfg_data;

  wtosc_req_if req_ch ();
  wtosc_rsp_if rsp_ch ();

  wavetable_oscillator_lerp i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // Predicted oscillator state.
  bit [wtosc_pkg::SAMPLE_W-1:0] wave_mem [wtosc_pkg::TABLE_DEPTH];
  longint osc_phase;
  bit [wtosc_pkg::GAIN_W-1:0] osc_gain;
  bit [wtosc_pkg::LENGTH_W-1:0] len_reg;
  bit [wtosc_pkg::INC_W-1:0] inc_reg;

  // Phase as seen by the requests queued so far, used to write entries before they are read.
  longint plan_phase;
  bit written [wtosc_pkg::TABLE_DEPTH];
  osc_req_t req_backlog [$];
  logic [wtosc_pkg::SAMPLE_W-1:0] samples_due [$];
  osc_req_t offer;

  int send_idle_pct;
  int recv_idle_pct;
  int gap_left;
  int stall_left;
  int hold_left;
  int results_seen;
  int errors;
  int n_ticks, n_writes, n_notes, n_ignored, n_settings;

  function automatic logic [wtosc_pkg::SAMPLE_W-1:0] interp_sample();
    longint len, span, ph, frac, a, b, mix, prod;
    int idx, nxt;
    len = len_reg;
    if (len == 0) len = 1;
    if (len > wtosc_pkg::TABLE_DEPTH) len = wtosc_pkg::TABLE_DEPTH;
    span = len << wtosc_pkg::PHASE_FRAC_BITS;
    ph = osc_phase % span;
    idx = int'(ph >> wtosc_pkg::PHASE_FRAC_BITS);
    frac = ph & ((longint'(1) << wtosc_pkg::PHASE_FRAC_BITS) - 1);
    nxt = idx + 1;
    if (nxt >= len) nxt = 0;
    a = $signed(wave_mem[idx]);
    b = $signed(wave_mem[nxt]);
    mix = (a * ((longint'(1) << wtosc_pkg::PHASE_FRAC_BITS) - frac) + b * frac)
          >>> wtosc_pkg::PHASE_FRAC_BITS;
    prod = (mix * longint'(osc_gain)) >>> 15;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    osc_phase = ph + longint'(inc_reg);
    return prod[wtosc_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic void apply_request(osc_req_t r);
    case (r.op)
      wtosc_pkg::OP_TICK: begin
        samples_due.push_back(interp_sample());
        n_ticks++;
      end
      wtosc_pkg::OP_WRITE: begin
        wave_mem[r.addr] = r.value;
        n_writes++;
      end
      wtosc_pkg::OP_NOTE: begin
        osc_gain = r.velocity;
        n_notes++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void queue_req(logic [wtosc_pkg::OPCODE_W-1:0] op,
                                    logic [wtosc_pkg::TADDR_W-1:0] addr,
                                    logic [wtosc_pkg::SAMPLE_W-1:0] value,
                                    logic [wtosc_pkg::GAIN_W-1:0] velocity);
    osc_req_t r;
    longint len, ph;
    int idx, nxt;
    if (op == wtosc_pkg::OP_TICK) begin
      len = len_reg;
      if (len == 0) len = 1;
      if (len > wtosc_pkg::TABLE_DEPTH) len = wtosc_pkg::TABLE_DEPTH;
      ph = plan_phase % (len << wtosc_pkg::PHASE_FRAC_BITS);
      idx = int'(ph >> wtosc_pkg::PHASE_FRAC_BITS);
      nxt = (idx + 1 >= len) ? 0 : idx + 1;
      if (!written[idx])
        queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(idx),
                  wtosc_pkg::SAMPLE_W'($urandom), '0);
      if (!written[nxt])
        queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(nxt),
                  wtosc_pkg::SAMPLE_W'($urandom), '0);
      plan_phase = ph + longint'(inc_reg);
    end
    r.op = op;
    r.addr = addr;
    r.value = value;
    r.velocity = velocity;
    if (op == wtosc_pkg::OP_WRITE) written[addr] = 1'b1;
    req_backlog.push_back(r);
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || samples_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int unsigned len, int unsigned inc);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= wtosc_pkg::CFG_TABLE_LENGTH;
    cfg_data <= wtosc_pkg::CFG_W'(len);
    @(posedge clk);
    cfg_index <= wtosc_pkg::CFG_PHASE_INCREMENT;
    cfg_data <= wtosc_pkg::CFG_W'(inc);
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = wtosc_pkg::LENGTH_W'(len);
    inc_reg = wtosc_pkg::INC_W'(inc);
    plan_phase = osc_phase;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic random_requests(int count);
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_req(wtosc_pkg::OP_TICK, wtosc_pkg::TADDR_W'($urandom),
                  wtosc_pkg::SAMPLE_W'($urandom), wtosc_pkg::GAIN_W'($urandom));
        done++;
      end else if (pick < 85) begin
        queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'($urandom),
                  wtosc_pkg::SAMPLE_W'($urandom), wtosc_pkg::GAIN_W'($urandom));
        done++;
      end else if (pick < 95) begin
        if ($urandom_range(4) == 0)
          queue_req(wtosc_pkg::OP_NOTE, wtosc_pkg::TADDR_W'($urandom),
                    wtosc_pkg::SAMPLE_W'($urandom), wtosc_pkg::GAIN_W'($urandom));
        else
          queue_req(wtosc_pkg::OP_NOTE, wtosc_pkg::TADDR_W'($urandom),
                    wtosc_pkg::SAMPLE_W'($urandom), wtosc_pkg::GAIN_W'($urandom_range(32768)));
        done++;
      end else begin
        queue_req(OP_UNUSED, wtosc_pkg::TADDR_W'($urandom),
                  wtosc_pkg::SAMPLE_W'($urandom), wtosc_pkg::GAIN_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_request(offer);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if ($urandom_range(99) < send_idle_pct) begin
          gap_left = $urandom_range(14);
          req_ch.valid <= 1'b0;
        end else begin
          offer = req_backlog.pop_front();
          req_ch.opcode <= offer.op;
          req_ch.table_address <= offer.addr;
          req_ch.table_value <= offer.value;
          req_ch.note_velocity <= offer.velocity;
          req_ch.valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (samples_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected sample %0d with no tick pending", $signed(rsp_ch.sample_out));
        end else if (rsp_ch.sample_out !== samples_due[0]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("sample %0d mismatch: expected %0d, got %0d", results_seen,
                     $signed(samples_due[0]), $signed(rsp_ch.sample_out));
          void'(samples_due.pop_front());
        end else begin
          void'(samples_due.pop_front());
        end
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        stall_left = $urandom_range(14);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned len, len_use, inc;
    int choice;
    req_ch.valid = 1'b0;
    req_ch.opcode = wtosc_pkg::OP_TICK;
    req_ch.table_address = '0;
    req_ch.table_value = '0;
    req_ch.note_velocity = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wtosc_pkg::CFG_TABLE_LENGTH;
    cfg_data = '0;
    osc_phase = 0;
    plan_phase = 0;
    osc_gain = '0;
    len_reg = wtosc_pkg::LENGTH_RESET;
    inc_reg = '0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero increment keeps the phase on entry 0.
    queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(0), 16'h7FFF, '0);
    queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(1), 16'h8000, '0);
    queue_req(wtosc_pkg::OP_NOTE, '0, '0, 16'h8000);
    queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);
    queue_req(wtosc_pkg::OP_NOTE, '1, '1, 16'hFFFF);
    queue_req(wtosc_pkg::OP_TICK, '1, '1, '1);
    queue_req(wtosc_pkg::OP_NOTE, '0, '0, 16'h0000);
    queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);
    queue_req(OP_UNUSED, '1, '1, '1);
    queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    // Two entries at half steps, so the next entry wraps back to index 0.
    set_config(2, 32'h8000);
    queue_req(wtosc_pkg::OP_NOTE, '0, '0, 16'hFFFF);
    repeat (4) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);
    queue_req(wtosc_pkg::OP_NOTE, '0, '0, 16'h8000);
    repeat (2) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    // Zero length acts as one entry; the increment is far above the length.
    set_config(0, 32'h7FF_FFFF);
    repeat (2) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);
    queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(0), 16'h8000, '0);
    queue_req(wtosc_pkg::OP_NOTE, '0, '0, 16'hFFFF);
    queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    set_config(1, 32'h1_8000);
    repeat (2) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    // Length above the store depth is limited to the full table.
    set_config(4095, 32'h7FF_8000);
    queue_req(wtosc_pkg::OP_WRITE, wtosc_pkg::TADDR_W'(2047), 16'h8000, '0);
    repeat (4) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    set_config(2048, 32'h1_0000);
    repeat (3) queue_req(wtosc_pkg::OP_TICK, '0, '0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      choice = $urandom_range(9);
      if (choice < 6) len = $urandom_range(64, 2);
      else if (choice < 7) len = $urandom_range(1);
      else len = $urandom_range(4095, 65);
      len_use = (len == 0) ? 1 : (len > wtosc_pkg::TABLE_DEPTH) ? wtosc_pkg::TABLE_DEPTH : len;
      choice = $urandom_range(9);
      if (choice < 5) inc = $urandom_range((len_use << wtosc_pkg::PHASE_FRAC_BITS) - 1);
      else if (choice < 8) inc = $urandom_range(32'h3_FFFF);
      else inc = $urandom_range(32'h7FF_FFFF);
      set_config(len, inc);
      if (p == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(2) * 15;
        recv_idle_pct = $urandom_range(2) * 15;
      end
      random_requests(PHASE_REQUESTS);
    end

    drain();
    $display("Sent %0d ticks, %0d table writes, %0d note starts and %0d ignored requests",
             n_ticks, n_writes, n_notes, n_ignored);
    $display("over %0d register settings; %0d samples checked, %0d mismatches.",
             n_settings + 1, results_seen, errors);
    if (errors == 0 && samples_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d requests queued and %0d samples outstanding.",
             req_backlog.size(), samples_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
